// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// check that a condition implies a second one in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// check that a condition implies a second one in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

// ===== hdl/bwf_pkg.sv =====
// package: types, constants and exp tables of the bilateral window filter
`default_nettype none
package bwf_pkg;
    localparam logic [1:0] REG_KERNEL_DIM = 2'd0;
    localparam logic [1:0] REG_SPATIAL    = 2'd1;
    localparam logic [1:0] REG_RANGE      = 2'd2;
    localparam logic [1:0] REG_MASK       = 2'd3;

    typedef struct packed {
        logic start;
        logic acc;
        logic fin;
        logic div_step;
        logic clear;
    } bwf_cmd_t;

    typedef struct packed {
        logic stage_done;
        logic div_done;
    } bwf_sts_t;

    function automatic logic [16:0] exp_int(input logic [3:0] n);
        case (n)
            4'd0: exp_int = 17'd65536;
            4'd1: exp_int = 17'd24109;
            4'd2: exp_int = 17'd8869;
            4'd3: exp_int = 17'd3263;
            4'd4: exp_int = 17'd1200;
            4'd5: exp_int = 17'd442;
            4'd6: exp_int = 17'd162;
            4'd7: exp_int = 17'd60;
            4'd8: exp_int = 17'd22;
            4'd9: exp_int = 17'd8;
            4'd10: exp_int = 17'd3;
            4'd11: exp_int = 17'd1;
            default: exp_int = 17'd0;
        endcase
    endfunction

    function automatic logic [16:0] exp_hi(input logic [3:0] k);
        case (k)
            4'd0: exp_hi = 17'd65536;
            4'd1: exp_hi = 17'd61565;
            4'd2: exp_hi = 17'd57835;
            4'd3: exp_hi = 17'd54331;
            4'd4: exp_hi = 17'd51039;
            4'd5: exp_hi = 17'd47947;
            4'd6: exp_hi = 17'd45042;
            4'd7: exp_hi = 17'd42313;
            4'd8: exp_hi = 17'd39750;
            4'd9: exp_hi = 17'd37341;
            4'd10: exp_hi = 17'd35079;
            4'd11: exp_hi = 17'd32954;
            4'd12: exp_hi = 17'd30957;
            4'd13: exp_hi = 17'd29081;
            4'd14: exp_hi = 17'd27319;
            default: exp_hi = 17'd25664;
        endcase
    endfunction

    function automatic logic [16:0] exp_lo(input logic [3:0] k);
        case (k)
            4'd0: exp_lo = 17'd65536;
            4'd1: exp_lo = 17'd65280;
            4'd2: exp_lo = 17'd65026;
            4'd3: exp_lo = 17'd64772;
            4'd4: exp_lo = 17'd64520;
            4'd5: exp_lo = 17'd64268;
            4'd6: exp_lo = 17'd64018;
            4'd7: exp_lo = 17'd63768;
            4'd8: exp_lo = 17'd63520;
            4'd9: exp_lo = 17'd63272;
            4'd10: exp_lo = 17'd63025;
            4'd11: exp_lo = 17'd62780;
            4'd12: exp_lo = 17'd62535;
            4'd13: exp_lo = 17'd62291;
            4'd14: exp_lo = 17'd62048;
            default: exp_lo = 17'd61806;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== hdl/bwf_ctrl.sv =====
// controller: sequences weight pipeline, accumulation and division
`default_nettype none
`include "assert_macros.svh"
module bwf_ctrl (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    input  wire              in_last,
    input  wire              out_stall,
    input  bwf_pkg::bwf_sts_t sts,
    output logic             in_stall,
    output logic             out_valid,
    output bwf_pkg::bwf_cmd_t cmd
);
    typedef enum logic [2:0] {S_IDLE, S_WORK, S_ACC, S_DIV, S_OUT} state_t;

    state_t state_reg;
    logic   last_reg;

    // command decode
    always_comb
    begin
        cmd          = '0;
        cmd.start    = (state_reg == S_IDLE) && in_valid;
        cmd.acc      = (state_reg == S_ACC);
        cmd.fin      = (state_reg == S_ACC) && last_reg;
        cmd.div_step = (state_reg == S_DIV);
        cmd.clear    = (state_reg == S_OUT) && !out_stall;
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    // state and registered flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        last_reg  <= in_last;
                        state_reg <= S_WORK;
                    end
                end
                S_WORK:
                begin
                    if (sts.stage_done)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    state_reg <= last_reg ? S_DIV : S_IDLE;
                end
                S_DIV:
                begin
                    if (sts.div_done)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_IMPL(a_out_only_final, clk, rst_n, out_valid, last_reg)
    `ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_IMPL(a_no_take_busy, clk, rst_n, cmd.start, !out_valid)
endmodule
`default_nettype wire

// ===== hdl/bwf_dp.sv =====
// datapath: offset, weight computation, accumulators and serial divider
`default_nettype none
`include "assert_macros.svh"
module bwf_dp #(
    parameter int MAX_KERNEL_DIM = 15,
    parameter int PIXEL_BITS     = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  bwf_pkg::bwf_cmd_t cmd,
    input  wire  [3:0]        kernel_dim,
    input  wire  [23:0]       spatial_coeff,
    input  wire  [31:0]       range_coeff,
    input  wire               circular_mask,
    input  wire  [15:0]       center_pixel,
    input  wire  [15:0]       neighbor_pixel,
    input  wire  [7:0]        element_index,
    output bwf_pkg::bwf_sts_t sts,
    output logic [15:0]       filtered_pixel
);
    localparam logic [16:0] FS   = 17'((1 << PIXEL_BITS) - 1);
    localparam logic [4:0]  MAXD = 5'(MAX_KERNEL_DIM);

    logic [4:0]  step_reg;
    logic [15:0] ctr_reg, nbr_reg;
    logic [7:0]  idx_reg;
    logic [4:0]  dim_reg;
    logic [7:0]  row_reg;
    logic        skip_reg;
    logic [16:0] dist2_reg;
    logic [16:0] dq_reg;
    logic [33:0] d2_reg;
    logic [47:0] pa_reg, pb_reg;
    logic [47:0] e_reg;
    logic [33:0] t_reg;
    logic [16:0] w_reg;
    logic [23:0] wt_reg;
    logic [39:0] pt_reg;
    logic [40:0] rem_reg;
    logic [40:0] quo_reg;
    logic [5:0]  dcnt_reg;
    logic [4:0]  rad;
    logic signed [17:0] dxs, dys;
    logic [16:0] dist2_c;
    logic [16:0] diff_c;
    logic [33:0] dqn_c;
    logic [24:0] wt_sum;
    logic [40:0] pt_sum;
    logic [40:0] rem_try;
    logic [40:0] num_c;

    function automatic logic [16:0] exp_i(input logic [47:0] e);
        exp_i = (e[47:16] >= 32'd12) ? 17'd0 : bwf_pkg::exp_int(e[19:16]);
    endfunction

    assign rad = (dim_reg - 5'd1) >> 1;
    assign dys = $signed({10'b0, row_reg}) - $signed({13'b0, rad});
    assign dxs = $signed({10'b0, idx_reg}) - $signed({13'b0, rad});
    assign dist2_c = 17'(dxs * dxs) + 17'(dys * dys);
    assign diff_c = (ctr_reg > nbr_reg) ? 17'(ctr_reg - nbr_reg) : 17'(nbr_reg - ctr_reg);
    assign dqn_c = 34'(diff_c) * 34'd65536 + 34'(FS >> 1);
    assign wt_sum = 25'(wt_reg) + 25'(w_reg);
    assign pt_sum = 41'(pt_reg) + 41'(w_reg) * 41'(nbr_reg);
    assign num_c = 41'(pt_reg) + 41'(wt_reg >> 1);
    assign rem_try = {rem_reg[39:0], quo_reg[40]};
    assign sts.stage_done = (step_reg == 5'd10);
    assign sts.div_done = (dcnt_reg == 6'd42);

    // stepped weight pipeline: row by subtraction, then dq, squares, exp
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            wt_reg   <= '0;
            pt_reg   <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                ctr_reg  <= 16'(center_pixel & FS[15:0]);
                nbr_reg  <= 16'(neighbor_pixel & FS[15:0]);
                idx_reg  <= element_index;
                row_reg  <= '0;
                dim_reg  <= (kernel_dim == 4'd0) ? 5'd1 :
                            ({1'b0, kernel_dim} > MAXD) ? MAXD : {1'b0, kernel_dim};
                step_reg <= 5'd1;
                dq_reg   <= '0;
            end
            else if (step_reg != 5'd0 && step_reg != 5'd10)
            begin
                case (step_reg)
                    5'd1:
                    begin
                        // index divide by repeated subtraction (at most 255 rows)
                        if ({3'b0, dim_reg} <= idx_reg)
                        begin
                            idx_reg <= idx_reg - {3'b0, dim_reg};
                            row_reg <= row_reg + 8'd1;
                        end
                        else
                            step_reg <= 5'd2;
                    end
                    5'd2:
                    begin
                        dist2_reg <= dist2_c;
                        skip_reg  <= circular_mask && (dist2_c > 17'(rad) * 17'(rad));
                        // dq numerator, reduced by FS in the next step
                        d2_reg    <= dqn_c;
                        step_reg  <= 5'd3;
                    end
                    5'd3:
                    begin
                        // FS is 2^P - 1: fold the high part back in, then one
                        // final compare and subtract
                        if ((d2_reg >> PIXEL_BITS) != 34'd0)
                        begin
                            dq_reg <= dq_reg + 17'(d2_reg >> PIXEL_BITS);
                            d2_reg <= (d2_reg & 34'(FS)) + (d2_reg >> PIXEL_BITS);
                        end
                        else if (d2_reg >= 34'(FS))
                        begin
                            dq_reg <= dq_reg + 17'd1;
                            d2_reg <= d2_reg - 34'(FS);
                        end
                        else
                            step_reg <= 5'd5;
                    end
                    5'd5:
                    begin
                        d2_reg   <= 34'(dq_reg) * 34'(dq_reg);
                        step_reg <= 5'd6;
                    end
                    5'd6:
                    begin
                        pa_reg   <= 48'(range_coeff) * 48'(d2_reg[33:16]);
                        pb_reg   <= 48'(range_coeff) * 48'(d2_reg[15:0]);
                        e_reg    <= 48'(spatial_coeff) * 48'(dist2_reg);
                        step_reg <= 5'd7;
                    end
                    5'd7:
                    begin
                        e_reg    <= e_reg + ((pa_reg + (pb_reg >> 16)) >> 15);
                        step_reg <= 5'd8;
                    end
                    5'd8:
                    begin
                        t_reg    <= (34'(exp_i(e_reg)) * 34'(bwf_pkg::exp_hi(e_reg[15:12]))
                                     + 34'd32768) >> 16;
                        step_reg <= 5'd9;
                    end
                    default:
                    begin
                        w_reg    <= 17'((t_reg * 34'(bwf_pkg::exp_lo(e_reg[11:8]))
                                     + 34'd32768) >> 16);
                        step_reg <= 5'd10;
                    end
                endcase
            end

            // accumulate with saturation
            if (cmd.acc)
            begin
                step_reg <= '0;
                if (!skip_reg)
                begin
                    wt_reg <= wt_sum[24] ? '1 : wt_sum[23:0];
                    pt_reg <= pt_sum[40] ? '1 : pt_sum[39:0];
                end
                if (cmd.fin)
                begin
                    dcnt_reg <= '0;
                    rem_reg  <= '0;
                end
            end

            // restoring divider, one quotient bit per cycle
            if (cmd.div_step && !sts.div_done)
            begin
                if (dcnt_reg == 6'd0)
                    quo_reg <= num_c;
                if (dcnt_reg != 6'd0)
                begin
                    if (rem_try >= 41'(wt_reg))
                    begin
                        rem_reg <= rem_try - 41'(wt_reg);
                        quo_reg <= {quo_reg[39:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_try;
                        quo_reg <= {quo_reg[39:0], 1'b0};
                    end
                end
                dcnt_reg <= dcnt_reg + 6'd1;
            end

            if (cmd.clear)
            begin
                wt_reg   <= '0;
                pt_reg   <= '0;
                dcnt_reg <= '0;
            end
        end
    end

    // clamp; empty weight yields zero
    always_comb
    begin
        if (wt_reg == '0)
            filtered_pixel = '0;
        else if (quo_reg > 41'(FS))
            filtered_pixel = FS[15:0];
        else
            filtered_pixel = quo_reg[15:0];
    end

    `ASSERT_IMPL(a_w_max, clk, rst_n, step_reg == 5'd10, w_reg <= 17'd65536)
    `ASSERT_NEXT(a_clear, clk, rst_n, cmd.clear, wt_reg == '0 && pt_reg == '0)
endmodule
`default_nettype wire

// ===== hdl/bilateral_window_filter.sv =====
// top level of the bilateral window filter
// usage:
//   input channel: center_pixel, neighbor_pixel, element_index, last_element
//   with in_valid/in_stall; a request is taken when in_valid is high and
//   in_stall low. one request is worked at a time.
//   output channel: filtered_pixel with out_valid/out_stall, one result per
//   window, given only for the request that carries last_element.
//   config channel: cfg_valid/cfg_ready, cfg_index, cfg_data; write only
//   while idle. index 0 kernel_dim, 1 spatial_coeff, 2 range_coeff,
//   3 circular_mask.
//   each request runs through a row search by repeated subtraction of
//   its index, the dq fold and the multiply and table stages before the
//   next one is taken; the last request also runs a serial divide
//   before its result shows.
//   reset clears totals and restores register defaults.
//   when out_stall is high the result holds and no new request is taken.
`default_nettype none
module bilateral_window_filter #(
    parameter int MAX_KERNEL_DIM = 15,
    parameter int PIXEL_BITS     = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire  [15:0] center_pixel,
    input  wire  [15:0] neighbor_pixel,
    input  wire  [7:0]  element_index,
    input  wire         last_element,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [15:0] filtered_pixel,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [31:0] cfg_data
);
    bwf_pkg::bwf_cmd_t cmd;
    bwf_pkg::bwf_sts_t sts;
    logic [3:0]  kdim_reg;
    logic [23:0] spat_reg;
    logic [31:0] rng_reg;
    logic        mask_reg;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kdim_reg <= 4'd5;
            spat_reg <= 24'd32768;
            rng_reg  <= 32'd3276800;
            mask_reg <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bwf_pkg::REG_KERNEL_DIM: kdim_reg <= cfg_data[3:0];
                bwf_pkg::REG_SPATIAL:    spat_reg <= cfg_data[23:0];
                bwf_pkg::REG_RANGE:      rng_reg  <= cfg_data;
                bwf_pkg::REG_MASK:       mask_reg <= cfg_data[0];
                default:                 mask_reg <= mask_reg;
            endcase
        end
    end

    bwf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last_element),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    bwf_dp #(
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM),
        .PIXEL_BITS     (PIXEL_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kernel_dim     (kdim_reg),
        .spatial_coeff  (spat_reg),
        .range_coeff    (rng_reg),
        .circular_mask  (mask_reg),
        .center_pixel   (center_pixel),
        .neighbor_pixel (neighbor_pixel),
        .element_index  (element_index),
        .sts            (sts),
        .filtered_pixel (filtered_pixel)
    );
endmodule
`default_nettype wire
